FILE: rtl/core/integer_cube_root_macros.svh
// Assertion macros used by the checker file
`ifndef INTEGER_CUBE_ROOT_MACROS_SVH
`define INTEGER_CUBE_ROOT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ICR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define ICR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/core/cbrt_pkg.sv
package cbrt_pkg;

	localparam int VALUE_W = 31;
	localparam int ROOT_W  = 11;
	localparam int STAGES  = 11;
	localparam int PAD_W   = 3 * STAGES;
	localparam int REM_W   = 26;
	localparam int PROD_W  = 2 * ROOT_W;
	localparam int TRIAL_W = PROD_W + 2;
	localparam logic [ROOT_W-1:0] ROOT_MAX = ROOT_W'(1290);

	typedef struct packed {
		logic              vld;
		logic [ROOT_W-1:0] y;
		logic [REM_W-1:0]  rem;
		logic [PAD_W-1:0]  val;
	} cbrt_stage_t;

endpackage

FILE: rtl/core/cbrt_stage.sv
module cbrt_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  cbrt_pkg::cbrt_stage_t din,
	output cbrt_pkg::cbrt_stage_t dout
);
	import cbrt_pkg::*;

	logic [REM_W-1:0]   rem_n;
	logic [ROOT_W-1:0]  y2;
	logic [PROD_W-1:0]  prod;
	logic [TRIAL_W-1:0] trial;
	logic               take;
	logic               vld_s;
	logic [ROOT_W-1:0]  y_s;
	logic [REM_W-1:0]   rem_s;
	logic [PAD_W-1:0]   val_s;

	// bring down the next three operand bits
	assign rem_n = {din.rem[REM_W-4:0], din.val[PAD_W-1 -: 3]};
	assign y2    = {din.y[ROOT_W-2:0], 1'b0};
	assign prod  = PROD_W'(y2) * PROD_W'(y2 + ROOT_W'(1));
	assign trial = TRIAL_W'(prod) + TRIAL_W'({prod, 1'b0}) + TRIAL_W'(1);
	assign take  = TRIAL_W'(rem_n) >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (en) begin
			vld_s <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s   <= take ? (y2 | ROOT_W'(1)) : y2;
			rem_s <= take ? REM_W'(TRIAL_W'(rem_n) - trial) : rem_n;
			val_s <= {din.val[PAD_W-4:0], 3'b000};
		end
	end

	assign dout = {vld_s, y_s, rem_s, val_s};

endmodule

FILE: rtl/core/integer_cube_root.sv
// Floor cube root of a 31-bit operand, one result bit per pipeline stage.
// A request passes every stage register before reaching the master side.
// Throughput: one request per cycle; the whole pipe holds while the output
// waits on m_tready, so a stall loses and repeats nothing.
// Reset: arst_n clears every stage's valid bit at once; no clearing pass.
module integer_cube_root (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [30:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [10:0] root
);
	import cbrt_pkg::*;

	cbrt_stage_t pipe [STAGES+1];
	logic        adv;

	// advance all stages together unless the last one is held
	assign adv      = !pipe[STAGES].vld || m_tready;
	assign s_tready = adv;

	assign pipe[0].vld = s_tvalid;
	assign pipe[0].y   = '0;
	assign pipe[0].rem = '0;
	assign pipe[0].val = PAD_W'(s_tdata[VALUE_W-1:0]);

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		cbrt_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.din    (pipe[i]),
			.dout   (pipe[i+1])
		);
	end

	assign m_tvalid = pipe[STAGES].vld;
	assign m_tdata  = {5'b00000, pipe[STAGES].y};

endmodule

FILE: rtl/core/integer_cube_root_checker.sv
`include "integer_cube_root_macros.svh"

module integer_cube_root_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);
	import cbrt_pkg::*;

	`ICR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`ICR_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready)
	`ICR_ASSERT_IMPL(a_root_range, clk, arst_n, m_tvalid, m_tdata[10:0] <= ROOT_MAX)
	`ICR_ASSERT_IMPL(a_stall_blocks, clk, arst_n, m_tvalid && !m_tready, !s_tready)

endmodule

bind integer_cube_root integer_cube_root_checker u_checker (.*);
